// File: hdl/tpcpwm_pkg.sv
// Shared types and constants of the three-phase center-aligned PWM core.
package tpcpwm_pkg;

   localparam int CountWidth   = 16;
   localparam int DeadWidth    = 10;
   localparam int DutyWidth    = 18;
   localparam int DutyFrac     = 16;
   localparam int NumPhases    = 3;
   localparam int NumGates     = 2 * NumPhases;
   localparam int CsrDataWidth = (CountWidth > DeadWidth) ? CountWidth : DeadWidth;
   localparam int CsrIndexWidth = 1;

   localparam logic [CountWidth-1:0]   PeakReset    = CountWidth'(250);
   localparam logic [DeadWidth-1:0]    DeadReset    = DeadWidth'(2);
   localparam logic [CountWidth-1:0]   CompareReset = PeakReset / 2;
   localparam logic [DeadWidth-1:0]    AgeMax       = {DeadWidth{1'b1}};
   localparam logic [DutyFrac:0]       DutyOne      = {1'b1, {DutyFrac{1'b0}}};

   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_DUTY = 2'd1,
      CMD_DISABLE  = 2'd2,
      CMD_BRAKE    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      FORCE_NONE  = 2'd0,
      FORCE_OFF   = 2'd1,
      FORCE_BRAKE = 2'd2
   } force_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HALF_PERIOD = 1'd0,
      CSR_DEAD        = 1'd1
   } csr_index_type;

   // Timer view handed to the phase units: values after this transfer.
   typedef struct packed {
      logic                  tick;
      logic                  at_zero;
      logic                  rising;
      logic [CountWidth-1:0] count;
   } timer_type;

endpackage

// File: hdl/tpcpwm_if.sv
// Valid/ready channel interfaces for the PWM command and gate result streams.
interface tpcpwm_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [1:0]                             command;
   logic signed [tpcpwm_pkg::DutyWidth-1:0] duty_u;
   logic signed [tpcpwm_pkg::DutyWidth-1:0] duty_v;
   logic signed [tpcpwm_pkg::DutyWidth-1:0] duty_w;

   modport source (output valid, command, duty_u, duty_v, duty_w, input ready);
   modport sink   (input valid, command, duty_u, duty_v, duty_w, output ready);
endinterface

interface tpcpwm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              gate_uh;
   logic                              gate_ul;
   logic                              gate_vh;
   logic                              gate_vl;
   logic                              gate_wh;
   logic                              gate_wl;
   logic [tpcpwm_pkg::CountWidth-1:0] count_value;
   logic                              counting_up;

   modport source (output valid, gate_uh, gate_ul, gate_vh, gate_vl, gate_wh, gate_wl,
                   count_value, counting_up, input ready);
   modport sink   (input valid, gate_uh, gate_ul, gate_vh, gate_vl, gate_wh, gate_wl,
                   count_value, counting_up, output ready);
endinterface

// File: hdl/tpcpwm_duty_scale.sv
// Clamps a signed Q1.16 duty to 0..1 and scales it by the half period.
module tpcpwm_duty_scale (
   input  logic signed [tpcpwm_pkg::DutyWidth-1:0]  duty,
   input  logic        [tpcpwm_pkg::CountWidth-1:0] peak,
   output logic        [tpcpwm_pkg::CountWidth-1:0] compare
);

   localparam int ProdWidth = tpcpwm_pkg::DutyFrac + 1 + tpcpwm_pkg::CountWidth;

   logic [tpcpwm_pkg::DutyFrac:0]   duty_clamped;
   logic [ProdWidth-1:0]            product;
   logic [tpcpwm_pkg::CountWidth:0] scaled;

   always_comb begin
      if (duty[tpcpwm_pkg::DutyWidth-1]) begin
         duty_clamped = '0;
      end else if (duty[tpcpwm_pkg::DutyWidth-2:0] >
                   (tpcpwm_pkg::DutyWidth-1)'(tpcpwm_pkg::DutyOne)) begin
         duty_clamped = tpcpwm_pkg::DutyOne;
      end else begin
         duty_clamped = duty[tpcpwm_pkg::DutyFrac:0];
      end
      product = ProdWidth'(duty_clamped) * ProdWidth'(peak);
      scaled  = product[ProdWidth-1:tpcpwm_pkg::DutyFrac];
      if (scaled > {1'b0, peak}) begin
         compare = peak;
      end else begin
         compare = scaled[tpcpwm_pkg::CountWidth-1:0];
      end
   end

endmodule

// File: hdl/tpcpwm_timer.sv
// Up-down center-aligned timer counter stepped by tick commands.
module tpcpwm_timer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              tick,
   input  logic [tpcpwm_pkg::CountWidth-1:0] peak,
   output tpcpwm_pkg::timer_type             timer
);

   logic [tpcpwm_pkg::CountWidth-1:0] count_ff, count_in, stepped;
   logic                              rising_ff, rising_in, rising_step;

   always_comb begin
      if (rising_ff) begin
         stepped     = (count_ff < peak) ? count_ff + 1'b1 : count_ff;
         rising_step = !(stepped >= peak);
      end else begin
         stepped     = (count_ff != '0) ? count_ff - 1'b1 : count_ff;
         rising_step = (stepped == '0);
      end
      count_in  = tick ? stepped : count_ff;
      rising_in = tick ? rising_step : rising_ff;

      timer.tick    = tick;
      timer.at_zero = (count_in == '0);
      timer.rising  = rising_in;
      timer.count   = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rising_ff <= 1'b1;
      end else begin
         count_ff  <= count_in;
         rising_ff <= rising_in;
      end
   end

endmodule

// File: hdl/tpcpwm_phase.sv
// One phase: shadow and active compare, raw level and dead-time edge age.
module tpcpwm_phase (
   input  logic                                     clock,
   input  logic                                     reset,
   input  tpcpwm_pkg::timer_type                    timer,
   input  logic                                     load_shadow,
   input  logic signed [tpcpwm_pkg::DutyWidth-1:0]  duty,
   input  logic        [tpcpwm_pkg::CountWidth-1:0] peak,
   input  logic        [tpcpwm_pkg::DeadWidth-1:0]  dead,
   output logic                                     raw_next,
   output logic                                     settled_next
);

   logic [tpcpwm_pkg::CountWidth-1:0] shadow_ff, shadow_in, active_ff, active_in;
   logic [tpcpwm_pkg::CountWidth-1:0] scaled;
   logic                              raw_ff, raw_in, level;
   logic [tpcpwm_pkg::DeadWidth-1:0]  age_ff, age_in;

   tpcpwm_duty_scale u_scale (
      .duty    (duty),
      .peak    (peak),
      .compare (scaled)
   );

   always_comb begin
      shadow_in = load_shadow ? scaled : shadow_ff;
      active_in = (timer.tick && timer.at_zero) ? shadow_ff : active_ff;
      level     = (active_in >= peak) || (timer.count < active_in);
      raw_in    = raw_ff;
      age_in    = age_ff;
      if (timer.tick) begin
         raw_in = level;
         if (level != raw_ff) begin
            age_in = '0;
         end else if (age_ff != tpcpwm_pkg::AgeMax) begin
            age_in = age_ff + 1'b1;
         end
      end
      raw_next     = raw_in;
      settled_next = (age_in >= dead);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_ff <= tpcpwm_pkg::CompareReset;
         active_ff <= tpcpwm_pkg::CompareReset;
         raw_ff    <= 1'b0;
         age_ff    <= tpcpwm_pkg::AgeMax;
      end else begin
         shadow_ff <= shadow_in;
         active_ff <= active_in;
         raw_ff    <= raw_in;
         age_ff    <= age_in;
      end
   end

endmodule

// File: hdl/three_phase_center_pwm_deadtime_core.sv
// Three-phase center-aligned PWM core with complementary gates and dead time.
// Takes one command transfer every cycle while the result register is empty
// or is being emptied in that same cycle; its result (six gate levels, counter
// value and direction) is registered and offered in the cycle after the
// transfer. The counter step, the compare and the dead-time age check run in
// a single combinational pass. Configuration writes take effect on the next
// transfer.
module three_phase_center_pwm_deadtime_core (
   input  logic                                   clock,
   input  logic                                   reset,
   tpcpwm_req_if.sink                             req_chan,
   tpcpwm_rsp_if.source                           rsp_chan,
   input  logic                                   csr_wen,
   input  logic [tpcpwm_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [tpcpwm_pkg::CsrDataWidth-1:0]    csr_wdata
);

   localparam int NumPhases = tpcpwm_pkg::NumPhases;

   logic [tpcpwm_pkg::CountWidth-1:0] peak_ff;
   logic [tpcpwm_pkg::DeadWidth-1:0]  dead_ff;
   tpcpwm_pkg::force_type             force_ff, force_in;
   tpcpwm_pkg::cmd_type               command;
   tpcpwm_pkg::timer_type             timer;
   logic                              accept, tick, set_duty;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [tpcpwm_pkg::NumGates-1:0]   gates_ff, gates_in;
   logic [tpcpwm_pkg::CountWidth-1:0] count_ff;
   logic                              up_ff;
   logic signed [tpcpwm_pkg::DutyWidth-1:0] duty [NumPhases];
   logic [NumPhases-1:0]              raw_next, settled_next;

   assign command         = tpcpwm_pkg::cmd_type'(req_chan.command);
   assign req_chan.ready  = !rsp_valid_ff || rsp_chan.ready;
   assign accept          = req_chan.valid && req_chan.ready;
   assign tick            = accept && (command == tpcpwm_pkg::CMD_TICK);
   assign set_duty        = accept && (command == tpcpwm_pkg::CMD_SET_DUTY);
   assign duty[0]         = req_chan.duty_u;
   assign duty[1]         = req_chan.duty_v;
   assign duty[2]         = req_chan.duty_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= tpcpwm_pkg::PeakReset;
         dead_ff <= tpcpwm_pkg::DeadReset;
      end else if (csr_wen) begin
         unique case (tpcpwm_pkg::csr_index_type'(csr_index))
            tpcpwm_pkg::CSR_HALF_PERIOD: begin
               peak_ff <= csr_wdata[tpcpwm_pkg::CountWidth-1:0];
            end
            tpcpwm_pkg::CSR_DEAD: begin
               dead_ff <= csr_wdata[tpcpwm_pkg::DeadWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   tpcpwm_timer u_timer (
      .clock (clock),
      .reset (reset),
      .tick  (tick),
      .peak  (peak_ff),
      .timer (timer)
   );

   for (genvar p = 0; p < NumPhases; p++) begin : g_phase
      tpcpwm_phase u_phase (
         .clock        (clock),
         .reset        (reset),
         .timer        (timer),
         .load_shadow  (set_duty),
         .duty         (duty[p]),
         .peak         (peak_ff),
         .dead         (dead_ff),
         .raw_next     (raw_next[p]),
         .settled_next (settled_next[p])
      );
   end

   always_comb begin
      force_in = force_ff;
      if (accept) begin
         unique case (command)
            tpcpwm_pkg::CMD_TICK:     force_in = force_ff;
            tpcpwm_pkg::CMD_SET_DUTY: force_in = tpcpwm_pkg::FORCE_NONE;
            tpcpwm_pkg::CMD_DISABLE:  force_in = tpcpwm_pkg::FORCE_OFF;
            default:                  force_in = tpcpwm_pkg::FORCE_BRAKE;
         endcase
      end
      // gates_in[2p+1] is the high side, gates_in[2p] the low side
      for (int p = 0; p < NumPhases; p++) begin
         case (force_in)
            tpcpwm_pkg::FORCE_OFF: begin
               gates_in[2*p+1] = 1'b0;
               gates_in[2*p]   = 1'b0;
            end
            tpcpwm_pkg::FORCE_BRAKE: begin
               gates_in[2*p+1] = 1'b0;
               gates_in[2*p]   = 1'b1;
            end
            default: begin
               gates_in[2*p+1] = raw_next[p] && settled_next[p];
               gates_in[2*p]   = !raw_next[p] && settled_next[p];
            end
         endcase
      end
      rsp_valid_in = accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         force_ff     <= tpcpwm_pkg::FORCE_OFF;
         rsp_valid_ff <= 1'b0;
      end else begin
         force_ff     <= force_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         gates_ff <= gates_in;
         count_ff <= timer.count;
         up_ff    <= timer.rising;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.gate_uh     = gates_ff[1];
   assign rsp_chan.gate_ul     = gates_ff[0];
   assign rsp_chan.gate_vh     = gates_ff[3];
   assign rsp_chan.gate_vl     = gates_ff[2];
   assign rsp_chan.gate_wh     = gates_ff[5];
   assign rsp_chan.gate_wl     = gates_ff[4];
   assign rsp_chan.count_value = count_ff;
   assign rsp_chan.counting_up = up_ff;

endmodule

// File: hdl/tpcpwm_checker.sv
// Port-level checks of the PWM core, bound to its top level.
module tpcpwm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_command,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [5:0]                        rsp_gates,
   input logic [tpcpwm_pkg::CountWidth-1:0] rsp_count
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gates) && $stable(rsp_count))
      else $error("result changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_xfer_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid)
      else $error("transfer produced no result");

   a_disable_gates: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command == tpcpwm_pkg::CMD_DISABLE |=> rsp_gates == 6'b000000)
      else $error("disable left a gate on");

   a_brake_gates: assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_command == tpcpwm_pkg::CMD_BRAKE |=> rsp_gates == 6'b010101)
      else $error("brake gate pattern wrong");

endmodule

bind three_phase_center_pwm_deadtime_core tpcpwm_checker u_tpcpwm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_command (req_chan.command),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_gates   ({rsp_chan.gate_uh, rsp_chan.gate_ul, rsp_chan.gate_vh,
                  rsp_chan.gate_vl, rsp_chan.gate_wh, rsp_chan.gate_wl}),
   .rsp_count   (rsp_chan.count_value)
);

// File: test/tpcpwm_scoreboard_pkg.sv
// Gate predictor and result scoreboard for the three-phase PWM core test.
package tpcpwm_scoreboard_pkg;
   import tpcpwm_pkg::*;

   typedef struct packed {
      logic                  gate_uh;
      logic                  gate_ul;
      logic                  gate_vh;
      logic                  gate_vl;
      logic                  gate_wh;
      logic                  gate_wl;
      logic [CountWidth-1:0] count_value;
      logic                  counting_up;
   } gate_sample_t;

   class gate_scoreboard;
      typedef logic [CountWidth+DutyFrac:0] product_t;

      logic [CountWidth-1:0] peak;
      logic [DeadWidth-1:0]  dead;
      logic [CountWidth-1:0] count;
      logic                  rising;
      logic [CountWidth-1:0] shadow [NumPhases];
      logic [CountWidth-1:0] active [NumPhases];
      logic                  raw [NumPhases];
      logic [DeadWidth-1:0]  age [NumPhases];
      force_type             force_mode;
      gate_sample_t          expected_gates [$];
      int                    mismatches;
      int                    results_seen;

      function new();
         peak = PeakReset;
         dead = DeadReset;
         count = '0;
         rising = 1'b1;
         for (int i = 0; i < NumPhases; i++) begin
            shadow[i] = CompareReset;
            active[i] = CompareReset;
            raw[i] = 1'b0;
            age[i] = AgeMax;
         end
         force_mode = FORCE_OFF;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function int pending();
         return expected_gates.size();
      endfunction

      function void write_register(csr_index_type idx, logic [CsrDataWidth-1:0] data);
         case (idx)
            CSR_HALF_PERIOD: peak = data[CountWidth-1:0];
            CSR_DEAD:        dead = data[DeadWidth-1:0];
            default: ;
         endcase
      endfunction

      // Clamp Q1.16 duty to 0..1, then scale by the half period.
      function logic [CountWidth-1:0] duty_to_compare(logic [DutyWidth-1:0] duty);
         logic [DutyFrac:0] clamped;
         product_t          scaled;
         if (duty[DutyWidth-1]) begin
            clamped = '0;
         end else if (duty > DutyOne) begin
            clamped = DutyOne;
         end else begin
            clamped = duty[DutyFrac:0];
         end
         scaled = (product_t'(clamped) * product_t'(peak)) >> DutyFrac;
         if (scaled > peak) begin
            scaled = peak;
         end
         return scaled[CountWidth-1:0];
      endfunction

      function void step_timer();
         logic lvl;
         if (rising) begin
            if (count < peak) begin
               count = count + 1'b1;
            end
            if (count >= peak) begin
               rising = 1'b0;
            end
         end else begin
            if (count != '0) begin
               count = count - 1'b1;
            end
            if (count == '0) begin
               rising = 1'b1;
            end
         end
         if (count == '0) begin
            for (int i = 0; i < NumPhases; i++) begin
               active[i] = shadow[i];
            end
         end
         for (int i = 0; i < NumPhases; i++) begin
            lvl = (active[i] >= peak) || (count < active[i]);
            if (lvl != raw[i]) begin
               raw[i] = lvl;
               age[i] = '0;
            end else if (age[i] < AgeMax) begin
               age[i] = age[i] + 1'b1;
            end
         end
      endfunction

      function void note_command(cmd_type cmd, logic [DutyWidth-1:0] du,
                                 logic [DutyWidth-1:0] dv, logic [DutyWidth-1:0] dw);
         logic [DutyWidth-1:0] duty [NumPhases];
         logic [NumGates-1:0]  gates;
         logic                 settled;
         gate_sample_t         want;
         duty[0] = du;
         duty[1] = dv;
         duty[2] = dw;
         case (cmd)
            CMD_TICK: step_timer();
            CMD_SET_DUTY: begin
               for (int i = 0; i < NumPhases; i++) begin
                  shadow[i] = duty_to_compare(duty[i]);
               end
               force_mode = FORCE_NONE;
            end
            CMD_DISABLE: force_mode = FORCE_OFF;
            default:     force_mode = FORCE_BRAKE;
         endcase
         for (int i = 0; i < NumPhases; i++) begin
            settled = age[i] >= dead;
            gates[2*i]   = raw[i] && settled;
            gates[2*i+1] = !raw[i] && settled;
            if (force_mode == FORCE_OFF) begin
               gates[2*i]   = 1'b0;
               gates[2*i+1] = 1'b0;
            end else if (force_mode == FORCE_BRAKE) begin
               gates[2*i]   = 1'b0;
               gates[2*i+1] = 1'b1;
            end
         end
         want.gate_uh = gates[0];
         want.gate_ul = gates[1];
         want.gate_vh = gates[2];
         want.gate_vl = gates[3];
         want.gate_wh = gates[4];
         want.gate_wl = gates[5];
         want.count_value = count;
         want.counting_up = rising;
         expected_gates.push_back(want);
      endfunction

      task report_mismatch(string what, logic [CountWidth-1:0] got,
                           logic [CountWidth-1:0] want);
         mismatches++;
         if (mismatches <= 100) begin
            $display("%0t result %0d: %s got %0d expected %0d",
                     $time, results_seen, what, got, want);
         end
      endtask

      task compare_field(string what, logic [CountWidth-1:0] got,
                         logic [CountWidth-1:0] want);
         if (got !== want) begin
            report_mismatch(what, got, want);
         end
      endtask

      task check_sample(gate_sample_t got);
         gate_sample_t want;
         if (expected_gates.size() == 0) begin
            report_mismatch("result with no command outstanding", '0, '0);
            return;
         end
         want = expected_gates.pop_front();
         compare_field("gate_uh", got.gate_uh, want.gate_uh);
         compare_field("gate_ul", got.gate_ul, want.gate_ul);
         compare_field("gate_vh", got.gate_vh, want.gate_vh);
         compare_field("gate_vl", got.gate_vl, want.gate_vl);
         compare_field("gate_wh", got.gate_wh, want.gate_wh);
         compare_field("gate_wl", got.gate_wl, want.gate_wl);
         compare_field("count_value", got.count_value, want.count_value);
         compare_field("counting_up", got.counting_up, want.counting_up);
         results_seen++;
      endtask
   endclass

endpackage

// File: test/three_phase_center_pwm_deadtime_core_test.sv
// Self-checking test of the three-phase center-aligned PWM core with dead time.
module three_phase_center_pwm_deadtime_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import tpcpwm_pkg::*;
   import tpcpwm_scoreboard_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     csr_wen;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_wdata;

   tpcpwm_req_if req_bus ();
   tpcpwm_rsp_if rsp_bus ();

   gate_scoreboard sb = new();

   bit send_idle;
   bit recv_idle;
   int hold_request;

   int phase_peak  [8] = '{2, 9, 40, 12, 65535, 5, 250, 0};
   int phase_dead  [8] = '{1, 3, 7, 1023, 1, 2, 2, 0};
   int phase_items [8] = '{200, 250, 250, 200, 100, 200, 200, 200};
   bit phase_stall [8] = '{1, 1, 0, 1, 1, 1, 1, 1};

   three_phase_center_pwm_deadtime_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_sample({rsp_bus.gate_uh, rsp_bus.gate_ul, rsp_bus.gate_vh,
                          rsp_bus.gate_vl, rsp_bus.gate_wh, rsp_bus.gate_wl,
                          rsp_bus.count_value, rsp_bus.counting_up});
      end
   end

   // Result side: random stalls, plus a long hold-off when requested.
   initial begin
      int stall;
      int hold;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         stall = recv_idle ? $urandom_range(0, 3) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   function automatic logic [DutyWidth-1:0] draw_duty();
      case ($urandom_range(0, 4))
         0: return DutyWidth'($urandom_range(0, 65536));
         1: return DutyWidth'($urandom_range(65537, 131071));
         2: return {1'b1, (DutyWidth-1)'($urandom)};
         3: return DutyWidth'($urandom);
         default: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return DutyWidth'(DutyOne);
               2: return DutyWidth'(DutyOne) - 1'b1;
               3: return {1'b0, {(DutyWidth-1){1'b1}}};
               4: return {1'b1, {(DutyWidth-1){1'b0}}};
               default: return '1;
            endcase
         end
      endcase
   endfunction

   task automatic send_item(cmd_type cmd, logic [DutyWidth-1:0] du,
                            logic [DutyWidth-1:0] dv, logic [DutyWidth-1:0] dw, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.duty_u  <= du;
      req_bus.duty_v  <= dv;
      req_bus.duty_w  <= dw;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_command(cmd, du, dv, dw);
   endtask

   // Called right after a transfer; lowers valid and waits for every result.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_config(logic [CountWidth-1:0] peak, logic [DeadWidth-1:0] dead);
      csr_wen   <= 1'b1;
      csr_index <= CSR_HALF_PERIOD;
      csr_wdata <= CsrDataWidth'(peak);
      @(posedge clock);
      sb.write_register(CSR_HALF_PERIOD, CsrDataWidth'(peak));
      csr_index <= CSR_DEAD;
      csr_wdata <= CsrDataWidth'(dead);
      @(posedge clock);
      sb.write_register(CSR_DEAD, CsrDataWidth'(dead));
      csr_wen <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      cmd_type              cmd;
      logic [DutyWidth-1:0] du;
      logic [DutyWidth-1:0] dv;
      logic [DutyWidth-1:0] dw;
      int                   pick;
      int                   peak;
      int                   dead;
      reset           <= 1'b1;
      csr_wen         <= 1'b0;
      csr_index       <= CSR_HALF_PERIOD;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.command <= CMD_TICK;
      req_bus.duty_u  <= '0;
      req_bus.duty_v  <= '0;
      req_bus.duty_w  <= '0;
      send_idle    = 1'b0;
      recv_idle    = 1'b0;
      hold_request = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: disabled gates, brake, duty extremes, force release
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_BRAKE, '0, '0, '0, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_SET_DUTY, {1'b1, 17'h0}, {1'b0, 17'h1ffff}, 18'h10000, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_SET_DUTY, 18'h0, 18'h0ffff, 18'h1, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_DISABLE, '1, '1, '1, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_BRAKE, '0, '0, '0, 0);
      send_item(CMD_SET_DUTY, '1, 18'h10001, 18'h08000, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      send_item(CMD_TICK, '0, '0, '0, 0);
      drain_results();

      for (int p = 0; p < 8; p++) begin
         peak = phase_peak[p];
         dead = phase_dead[p];
         if (p == 7) begin
            peak = $urandom_range(2, 30);
            dead = $urandom_range(1, 8);
         end
         set_config(CountWidth'(peak), DeadWidth'(dead));
         send_idle = phase_stall[p];
         recv_idle = phase_stall[p];
         if (p == 1) begin
            hold_request = 60;
         end
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n == phase_items[p] / 2) begin
               drain_results();
            end
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
               cmd = CMD_TICK;
            end else if (pick < 92) begin
               cmd = CMD_SET_DUTY;
            end else if (pick < 96) begin
               cmd = CMD_DISABLE;
            end else begin
               cmd = CMD_BRAKE;
            end
            du = draw_duty();
            dv = draw_duty();
            dw = draw_duty();
            send_item(cmd, du, dv, dw, send_idle ? $urandom_range(0, 3) : 0);
         end
         drain_results();
      end

      repeat (4) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/tpcpwm_pkg.sv
hdl/tpcpwm_if.sv
hdl/tpcpwm_duty_scale.sv
hdl/tpcpwm_timer.sv
hdl/tpcpwm_phase.sv
hdl/three_phase_center_pwm_deadtime_core.sv
hdl/tpcpwm_checker.sv
test/tpcpwm_scoreboard_pkg.sv
test/three_phase_center_pwm_deadtime_core_test.sv
